// ----- design/blr_pkg.sv -----
// ----------------------------------------------------------------------------
// blr_pkg
// Shared widths, defaults and controller/datapath interface types for the
// line rasteriser.
// ----------------------------------------------------------------------------
package blr_pkg;

	localparam int COORD_W          = 6;
	localparam int COORD_BITS_DEF   = 6;

	typedef struct packed {
		logic load;
		logic advance;
	} blr_cmd_t;

	typedef struct packed {
		logic last;
	} blr_status_t;

endpackage

// ----- design/blr_ctrl.sv -----
// ----------------------------------------------------------------------------
// blr_ctrl
// Line controller: accepts a line, then steps the datapath once per output
// transfer until the final pixel has gone.
// ----------------------------------------------------------------------------
module blr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  blr_pkg::blr_status_t status,
	output blr_pkg::blr_cmd_t    cmd
);
	import blr_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic state_q;
	logic state_d;
	logic advance;
	logic load;

	assign advance   = (state_q == ST_RUN) && !out_stall;
	assign in_stall  = !((state_q == ST_IDLE) || (advance && status.last));
	assign load      = in_valid && !in_stall;
	assign out_valid = (state_q == ST_RUN);

	assign cmd.load    = load;
	assign cmd.advance = advance;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (load) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (load) begin
					state_d = ST_RUN;
				end else if (advance && status.last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- design/blr_datapath.sv -----
// ----------------------------------------------------------------------------
// blr_datapath
// Endpoint ordering, Bresenham set-up and the per-pixel step of position,
// decision variable and remaining-pixel count.
// ----------------------------------------------------------------------------
module blr_datapath #(
	parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF
) (
	input  logic                        clk,
	input  logic [blr_pkg::COORD_W-1:0] x_start,
	input  logic [blr_pkg::COORD_W-1:0] y_start,
	input  logic [blr_pkg::COORD_W-1:0] x_end,
	input  logic [blr_pkg::COORD_W-1:0] y_end,
	input  blr_pkg::blr_cmd_t           cmd,
	output blr_pkg::blr_status_t        status,
	output logic [blr_pkg::COORD_W-1:0] pixel_x,
	output logic [blr_pkg::COORD_W-1:0] pixel_y,
	output logic                        last_pixel
);
	import blr_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int DW = COORD_BITS + 3;

	logic [CB-1:0]        ax, ay, bx, by;
	logic [CB-1:0]        lx, ly, rx, ry;
	logic                 swap;
	logic [CB-1:0]        dx_u;
	logic signed [CB:0]   dy;
	logic [CB-1:0]        ady;
	logic                 neg;
	logic                 ymaj;
	logic signed [DW-1:0] sdx, sdy;
	logic signed [DW-1:0] d0, inc_s0, inc_n0;

	logic [CB-1:0]        x_q, y_q, cnt_q;
	logic signed [DW-1:0] d_q, inc_s_q, inc_n_q;
	logic                 neg_q, ymaj_q;
	logic                 step;
	logic [CB-1:0]        y_next;

	assign ax = x_start[CB-1:0];
	assign ay = y_start[CB-1:0];
	assign bx = x_end[CB-1:0];
	assign by = y_end[CB-1:0];

	assign swap = ax > bx;
	assign lx   = swap ? bx : ax;
	assign ly   = swap ? by : ay;
	assign rx   = swap ? ax : bx;
	assign ry   = swap ? ay : by;

	assign dx_u = rx - lx;
	assign dy   = $signed({1'b0, ry}) - $signed({1'b0, ly});
	assign neg  = !(dy > 0);
	assign ady  = neg ? (ly - ry) : (ry - ly);
	assign ymaj = ady >= dx_u;
	assign sdx  = $signed(DW'(dx_u));
	assign sdy  = DW'(dy);

	always_comb begin
		case ({neg, ymaj})
			2'b00: begin
				d0     = (sdy <<< 1) - sdx;
				inc_s0 = (sdy - sdx) <<< 1;
				inc_n0 = sdy <<< 1;
			end
			2'b01: begin
				d0     = (sdx <<< 1) - sdy;
				inc_s0 = (sdx - sdy) <<< 1;
				inc_n0 = sdx <<< 1;
			end
			2'b10: begin
				d0     = (sdy <<< 1) + sdx;
				inc_s0 = (sdy + sdx) <<< 1;
				inc_n0 = sdy <<< 1;
			end
			2'b11: begin
				d0     = -(sdx <<< 1) - sdy;
				inc_s0 = -((sdx + sdy) <<< 1);
				inc_n0 = -(sdx <<< 1);
			end
			default: begin
				d0     = '0;
				inc_s0 = '0;
				inc_n0 = '0;
			end
		endcase
	end

	assign step   = neg_q ? (d_q <= 0) : (d_q >= 0);
	assign y_next = neg_q ? (y_q - 1'b1) : (y_q + 1'b1);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q     <= lx;
			y_q     <= ly;
			cnt_q   <= ymaj ? ady : dx_u;
			d_q     <= d0;
			inc_s_q <= inc_s0;
			inc_n_q <= inc_n0;
			neg_q   <= neg;
			ymaj_q  <= ymaj;
		end else if (cmd.advance) begin
			cnt_q <= cnt_q - 1'b1;
			d_q   <= d_q + (step ? inc_s_q : inc_n_q);
			if (ymaj_q) begin
				y_q <= y_next;
				if (step) begin
					x_q <= x_q + 1'b1;
				end
			end else begin
				x_q <= x_q + 1'b1;
				if (step) begin
					y_q <= y_next;
				end
			end
		end
	end

	assign status.last = (cnt_q == '0);
	assign pixel_x     = COORD_W'(x_q);
	assign pixel_y     = COORD_W'(y_q);
	assign last_pixel  = status.last;

endmodule

// ----- design/bresenham_line_rasterizer_top.sv -----
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_top
// Bresenham line rasteriser for a square tile of 2^COORD_BITS pixels a side.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one line as two endpoints.
//   Only the low COORD_BITS bits of each coordinate are used. Endpoints are
//   reordered so the walk runs left to right (vertical lines run from the
//   first y to the second).
//   Output channel (out_valid/out_stall) carries one pixel per transfer,
//   with last_pixel set on the final pixel of the line.
//   A line of N = max(|dx|, |dy|) + 1 pixels, at most 2^COORD_BITS, shows its
//   first pixel the cycle after the input transfer and then moves one pixel
//   per unstalled cycle; the next line is taken in the cycle of the final
//   pixel transfer, so the pixels of successive lines follow without a gap.
//   The walk is done by the single stepping datapath: one pixel per step.
//   A stall on the output holds the current pixel and freezes the walk; the
//   input stays stalled until the last pixel transfers.
//   Reset returns the controller to idle; no line is in flight after it.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer_top #(
	parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [blr_pkg::COORD_W-1:0] x_start,
	input  logic [blr_pkg::COORD_W-1:0] y_start,
	input  logic [blr_pkg::COORD_W-1:0] x_end,
	input  logic [blr_pkg::COORD_W-1:0] y_end,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [blr_pkg::COORD_W-1:0] pixel_x,
	output logic [blr_pkg::COORD_W-1:0] pixel_y,
	output logic                        last_pixel
);
	import blr_pkg::*;

	blr_cmd_t    cmd;
	blr_status_t status;

	blr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	blr_datapath #(
		.COORD_BITS (COORD_BITS)
	) u_datapath (
		.clk        (clk),
		.x_start    (x_start),
		.y_start    (y_start),
		.x_end      (x_end),
		.y_end      (y_end),
		.cmd        (cmd),
		.status     (status),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.last_pixel (last_pixel)
	);

endmodule

// ----- design/blr_checker.sv -----
// ----------------------------------------------------------------------------
// blr_checker
// Port-level checks on the line rasteriser, bound to the top level.
// ----------------------------------------------------------------------------
module blr_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [blr_pkg::COORD_W-1:0] pixel_x,
	input logic [blr_pkg::COORD_W-1:0] pixel_y,
	input logic                        last_pixel
);
	import blr_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_x) &&
			$stable(pixel_y) && $stable(last_pixel))
		else $error("stalled pixel changed");

	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> out_valid)
		else $error("no pixel after line transfer");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !in_stall |-> last_pixel && !out_stall)
		else $error("line taken while pixels remain");

	a_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_pixel |=> out_valid)
		else $error("line ended without last pixel");

endmodule

bind bresenham_line_rasterizer_top blr_checker u_blr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.pixel_x    (pixel_x),
	.pixel_y    (pixel_y),
	.last_pixel (last_pixel)
);

// ----- sim/bresenham_line_rasterizer_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_top_test
// Feeds lines to the rasteriser and checks every pixel, in order, against a
// behavioural line walker. A short directed set of edge cases comes first,
// then random lines, under three patterns of sender and receiver idling and
// one long output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer_top_test;

	import blr_pkg::*;

	localparam int TILE_BITS   = COORD_BITS_DEF;
	localparam int TILE_MASK   = (1 << TILE_BITS) - 1;
	localparam int N_RANDOM    = 470;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 20;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int MAX_REPORTS = 50;

	typedef logic [COORD_W-1:0] coord_t;

	typedef struct {
		coord_t xa;
		coord_t ya;
		coord_t xb;
		coord_t yb;
	} line_t;

	typedef struct {
		coord_t x;
		coord_t y;
		logic   last;
	} pixel_t;

	logic   clk        = 1'b0;
	logic   arst_n     = 1'b0;
	logic   in_valid   = 1'b0;
	logic   in_stall;
	coord_t x_start    = '0;
	coord_t y_start    = '0;
	coord_t x_end      = '0;
	coord_t y_end      = '0;
	logic   out_valid;
	logic   out_stall  = 1'b0;
	coord_t pixel_x;
	coord_t pixel_y;
	logic   last_pixel;

	line_t  line_queue[$];
	pixel_t pixel_queue[$];

	int lines_total;
	int lines_directed;
	int lines_done     = 0;
	int pixels_checked = 0;
	int longest_line   = 0;
	int mismatches     = 0;
	int cycle_count    = 0;
	int hold_left      = 0;
	bit hold_done      = 1'b0;
	int send_idle_pct;
	int recv_idle_pct;

	bresenham_line_rasterizer_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.x_start    (x_start),
		.y_start    (y_start),
		.x_end      (x_end),
		.y_end      (y_end),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.last_pixel (last_pixel)
	);

	always #5 clk = ~clk;

	function automatic void put_pixel(int x, int y);
		pixel_t p;
		p.x    = coord_t'(x & TILE_MASK);
		p.y    = coord_t'(y & TILE_MASK);
		p.last = 1'b0;
		pixel_queue.push_back(p);
	endfunction

	// expected pixels of one line, appended to pixel_queue in walk order
	task automatic trace_line(input line_t ln);
		int ax, ay, bx, by;
		int lx, ly, rx, ry;
		int dx, dy, x, y, d, s, first;
		ax = int'(ln.xa) & TILE_MASK;
		ay = int'(ln.ya) & TILE_MASK;
		bx = int'(ln.xb) & TILE_MASK;
		by = int'(ln.yb) & TILE_MASK;
		first = pixel_queue.size();
		if (ax > bx) begin
			lx = bx; ly = by; rx = ax; ry = ay;
		end else begin
			lx = ax; ly = ay; rx = bx; ry = by;
		end
		dx = rx - lx;
		dy = ry - ly;
		x  = lx;
		y  = ly;
		if (dx == 0) begin
			s = (ly > ry) ? -1 : 1;
			while (y != ry) begin
				put_pixel(x, y);
				y += s;
			end
			put_pixel(rx, ry);
		end else if (dy == 0) begin
			for (x = lx; x <= rx; x++)
				put_pixel(x, y);
		end else if (dx == dy) begin
			while (x <= rx) begin
				put_pixel(x, y);
				x++; y++;
			end
		end else if (dx == -dy) begin
			while (x <= rx) begin
				put_pixel(x, y);
				x++; y--;
			end
		end else if (dy > 0) begin
			if (dy < dx) begin
				d = 2 * dy - dx;
				while (x <= rx) begin
					put_pixel(x, y);
					if (d >= 0) begin
						y++; d += 2 * (dy - dx);
					end else
						d += 2 * dy;
					x++;
				end
			end else begin
				d = 2 * dx - dy;
				while (y <= ry) begin
					put_pixel(x, y);
					if (d >= 0) begin
						x++; d += 2 * (dx - dy);
					end else
						d += 2 * dx;
					y++;
				end
			end
		end else begin
			// negative slope: mirrored decision variable, steps at or below zero
			if (-dy < dx) begin
				d = 2 * dy + dx;
				while (x <= rx) begin
					put_pixel(x, y);
					if (d <= 0) begin
						y--; d += 2 * (dy + dx);
					end else
						d += 2 * dy;
					x++;
				end
			end else begin
				d = -2 * dx - dy;
				while (y >= ry) begin
					put_pixel(x, y);
					if (d <= 0) begin
						x++; d += -2 * dx - 2 * dy;
					end else
						d += -2 * dx;
					y--;
				end
			end
		end
		if (pixel_queue.size() > first)
			pixel_queue[pixel_queue.size() - 1].last = 1'b1;
		if (pixel_queue.size() - first > longest_line)
			longest_line = pixel_queue.size() - first;
	endtask

	task automatic queue_line(int xa, int ya, int xb, int yb);
		line_t ln;
		ln.xa = coord_t'(xa);
		ln.ya = coord_t'(ya);
		ln.xb = coord_t'(xb);
		ln.yb = coord_t'(yb);
		line_queue.push_back(ln);
	endtask

	task automatic report_mismatch(string what, int got, int want);
		if (mismatches < MAX_REPORTS)
			$display("ERROR @%0t: %s got %0d expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	// idling pattern by progress through the line list
	always_comb begin
		if (lines_done < lines_total / 3) begin
			send_idle_pct = 31;
			recv_idle_pct = 87;
		end else if (lines_done < 2 * lines_total / 3) begin
			send_idle_pct = 87;
			recv_idle_pct = 31;
		end else begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
	end

	// sender
	always @(posedge clk) begin
		bit    take;
		bit    idle;
		line_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			take = in_valid && !in_stall;
			if (take) begin
				trace_line(line_queue.pop_front());
				lines_done <= lines_done + 1;
			end
			if (!in_valid || take) begin
				idle = $urandom_range(0, 99) < send_idle_pct;
				if (line_queue.size() != 0 && !idle) begin
					nxt = line_queue[0];
					in_valid <= 1'b1;
					x_start  <= nxt.xa;
					y_start  <= nxt.ya;
					x_end    <= nxt.xb;
					y_end    <= nxt.yb;
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// long output hold-off two lines into the unthrottled phase
	always @(posedge clk) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (!hold_done && lines_done == 2 * lines_total / 3 + 2) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	always @(posedge clk) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else
			out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_idle_pct);
	end

	// pixel checker
	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pixel_queue.size() == 0) begin
				report_mismatch("unexpected pixel, x", pixel_x, -1);
			end else begin
				want = pixel_queue.pop_front();
				if (pixel_x !== want.x)
					report_mismatch("pixel_x", pixel_x, want.x);
				if (pixel_y !== want.y)
					report_mismatch("pixel_y", pixel_y, want.y);
				if (last_pixel !== want.last)
					report_mismatch("last_pixel", last_pixel, want.last);
				pixels_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d pixels outstanding",
				cycle_count, pixel_queue.size());
			$display("FAIL bresenham_line_rasterizer_top");
			$finish;
		end
	end

	initial begin
		int kind, xa, ya, xb, yb, len;

		// single pixels, full-tile runs both ways, tie pixels on every slope class
		queue_line( 0,  0,  0,  0);
		queue_line(63, 63, 63, 63);
		queue_line( 0,  0, 63,  0);
		queue_line(63,  5,  0,  5);
		queue_line( 7,  0,  7, 63);
		queue_line( 7, 63,  7,  0);
		queue_line( 0,  0, 63, 63);
		queue_line(63, 63,  0,  0);
		queue_line( 0, 63, 63,  0);
		queue_line(63,  0,  0, 63);
		queue_line( 0,  0, 63, 20);
		queue_line( 3,  0, 20, 63);
		queue_line( 0, 40, 63, 10);
		queue_line( 5, 63, 30,  0);
		queue_line( 0,  0,  4,  2);
		queue_line( 0,  2,  4,  0);
		queue_line( 0,  0,  2,  4);
		queue_line( 0,  4,  2,  0);
		queue_line(20,  0,  3, 63);
		queue_line(63, 62,  0, 61);
		queue_line( 1,  1,  2,  3);
		queue_line(42, 21, 42, 21);
		lines_directed = line_queue.size();

		for (int i = 0; i < N_RANDOM; i++) begin
			kind = $urandom_range(0, 9);
			xa = $urandom_range(0, 63);
			ya = $urandom_range(0, 63);
			xb = $urandom_range(0, 63);
			yb = $urandom_range(0, 63);
			case (kind)
				0: xb = xa;
				1: yb = ya;
				2: begin
					len = $urandom_range(0, 63);
					xa  = $urandom_range(0, 63 - len);
					xb  = xa + len;
					ya  = $urandom_range(0, 63 - len);
					yb  = ya + len;
					if ($urandom_range(0, 1)) begin
						ya = 63 - ya;
						yb = 63 - yb;
					end
					if ($urandom_range(0, 1)) begin
						len = xa; xa = xb; xb = len;
						len = ya; ya = yb; yb = len;
					end
				end
				3: begin
					xb = (xa + $urandom_range(0, 7) - 3) & TILE_MASK;
					yb = (ya + $urandom_range(0, 7) - 3) & TILE_MASK;
				end
				default: ;
			endcase
			queue_line(xa, ya, xb, yb);
		end
		lines_total = line_queue.size();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (line_queue.size() != 0 || in_valid || pixel_queue.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d lines (%0d directed), %0d pixels checked, longest %0d pixels",
			lines_done, lines_directed, pixels_checked, longest_line);
		$display("idling 31/87, 87/31, none; output hold-off of %0d cycles applied: %0d",
			HOLD_CYCLES, hold_done);
		if (mismatches == 0)
			$display("PASS bresenham_line_rasterizer_top");
		else
			$display("FAIL bresenham_line_rasterizer_top");
		$finish;
	end

endmodule

// ----- filelist.f -----
design/blr_pkg.sv
design/blr_ctrl.sv
design/blr_datapath.sv
design/bresenham_line_rasterizer_top.sv
design/blr_checker.sv
sim/bresenham_line_rasterizer_top_test.sv
